FILE: rtl/core/grss_pkg.sv
// Shared types, codes and helpers for the gyro rolling-shutter shift block.
// No dependencies; imported by every module in rtl/core except grss_ram.
package grss_pkg;

   localparam int DIV_NUM_W = 51;   // divider dividend width
   localparam int DIV_DEN_W = 32;   // divider divisor width
   localparam int NUM_W     = 50;   // signed numerator width ahead of the divider

   localparam logic [6:0]  RST_NUM_DIV  = 7'd8;
   localparam logic [9:0]  RST_PERIOD   = 10'd33;
   localparam logic [15:0] RST_GAIN     = 16'd0;
   localparam logic        RST_VERT     = 1'b1;
   localparam logic [15:0] RST_MAX_DLY  = 16'd100;

   typedef enum logic [1:0] {
      ACT_LOAD  = 2'd0,
      ACT_CLEAR = 2'd1,
      ACT_FRAME = 2'd2,
      ACT_NONE  = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      CSR_NUM_DIV = 3'd0,
      CSR_PERIOD  = 3'd1,
      CSR_GAIN    = 3'd2,
      CSR_VERT    = 3'd3,
      CSR_MAX_DLY = 3'd4
   } csr_idx_type;

   // what the shared divider is currently working on
   typedef enum logic [2:0] {
      OP_OFF  = 3'd0,
      OP_INTY = 3'd1,
      OP_INTZ = 3'd2,
      OP_SHX  = 3'd3,
      OP_SHY  = 3'd4
   } op_type;

   typedef struct packed {
      logic   load;
      logic   clear;
      logic   frame_start;
      logic   next_div;
      logic   scan_next;
      logic   latch_a;
      logic   set_fallback;
      logic   set_fail;
      logic   num_load;
      logic   div_start;
      logic   div_store;
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic hist_empty;
      logic ge;
      logic k_first;
      logic k_last;
      logic fb_ok;
      logic last_div;
   } sts_type;

   function automatic logic signed [23:0] sat24(input logic signed [24:0] v);
      logic signed [23:0] r;
      if (v > 25'sd8388607) r = 24'sh7FFFFF;
      else if (v < -25'sd8388608) r = 24'sh800000;
      else r = v[23:0];
      return r;
   endfunction

endpackage

FILE: rtl/core/grss_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module grss_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule

FILE: rtl/core/grss_div.sv
// Restoring divider, one quotient bit per cycle, unsigned operands.
// Depends on grss_pkg for operand widths.
module grss_div (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [grss_pkg::DIV_NUM_W-1:0]  dividend,
   input  logic [grss_pkg::DIV_DEN_W-1:0]  divisor,
   output logic [grss_pkg::DIV_NUM_W-1:0]  quotient,
   output logic                            done
);
   import grss_pkg::*;

   localparam int CNT_W = $clog2(DIV_NUM_W + 1);

   logic [DIV_NUM_W-1:0] quo_ff, quo_in;
   logic [DIV_DEN_W-1:0] rem_ff, rem_in, den_ff, den_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic                 busy_ff, busy_in, done_ff, done_in;
   logic [DIV_DEN_W:0]   trial;
   logic                 take;

   assign trial = {rem_ff, quo_ff[DIV_NUM_W-1]};
   assign take  = trial >= {1'b0, den_ff};

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         den_in  = divisor;
         cnt_in  = CNT_W'(DIV_NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = take ? DIV_DEN_W'(trial - {1'b0, den_ff}) : trial[DIV_DEN_W-1:0];
         quo_in = {quo_ff[DIV_NUM_W-2:0], take};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign quotient = quo_ff;
   assign done     = done_ff;
endmodule

FILE: rtl/core/grss_dp.sv
// Datapath: config registers, gyro history, offset/interpolation/shift math.
// Depends on grss_pkg, grss_ram, grss_div.
module grss_dp #(
   parameter int HIST_DEPTH = 32,
   parameter int MAX_DIV    = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_valid,
   input  logic [2:0]           csr_index,
   input  logic [15:0]          csr_data,
   input  logic [31:0]          req_timestamp,
   input  logic signed [15:0]   req_gyro_y,
   input  logic signed [15:0]   req_gyro_z,
   input  grss_pkg::cmd_type    cmd,
   output grss_pkg::sts_type    sts,
   output logic signed [23:0]   rsp_shift_x,
   output logic signed [23:0]   rsp_shift_y,
   output logic                 rsp_band_failed,
   output logic                 rsp_last_band
);
   import grss_pkg::*;

   localparam int AW = $clog2(HIST_DEPTH);
   localparam int CW = $clog2(HIST_DEPTH + 1);
   localparam int OW = CW + 1;

   // configuration
   logic [6:0]  ndiv_ff;
   logic [9:0]  period_ff;
   logic [15:0] gain_ff, maxdly_ff;
   logic        vert_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ndiv_ff   <= RST_NUM_DIV;
         period_ff <= RST_PERIOD;
         gain_ff   <= RST_GAIN;
         vert_ff   <= RST_VERT;
         maxdly_ff <= RST_MAX_DLY;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_NUM_DIV: ndiv_ff   <= csr_data[6:0];
            CSR_PERIOD:  period_ff <= csr_data[9:0];
            CSR_GAIN:    gain_ff   <= csr_data;
            CSR_VERT:    vert_ff   <= csr_data[0];
            CSR_MAX_DLY: maxdly_ff <= csr_data;
            default: ;
         endcase
      end
   end

   logic [6:0] n_eff;
   assign n_eff = (ndiv_ff == 7'd0) ? 7'd1 :
                  (ndiv_ff > 7'(MAX_DIV)) ? 7'(MAX_DIV) : ndiv_ff;

   // history ring
   logic [AW-1:0] head_ff, head_in;
   logic [CW-1:0] count_ff, count_in, k_ff, k_in;
   logic [OW-1:0] old_sum, oldest, rd_sum;
   logic [AW-1:0] raddr;
   logic [63:0]   rdata;
   logic [31:0]   rd_t;
   logic signed [15:0] rd_y, rd_z;

   assign rd_t = rdata[63:32];
   assign rd_y = rdata[31:16];
   assign rd_z = rdata[15:0];

   assign old_sum = OW'(head_ff) + OW'(HIST_DEPTH) - OW'(count_ff);
   assign oldest  = (old_sum >= OW'(HIST_DEPTH)) ? old_sum - OW'(HIST_DEPTH) : old_sum;
   assign rd_sum  = oldest + OW'(k_ff);
   assign raddr   = (rd_sum >= OW'(HIST_DEPTH)) ? AW'(rd_sum - OW'(HIST_DEPTH))
                                                : AW'(rd_sum);

   grss_ram #(.WIDTH(64), .DEPTH(HIST_DEPTH)) u_hist (
      .clock (clock),
      .we    (cmd.load),
      .waddr (head_ff),
      .wdata ({req_timestamp, req_gyro_y, req_gyro_z}),
      .raddr (raddr),
      .rdata (rdata)
   );

   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      if (cmd.load) begin
         head_in = (head_ff == AW'(HIST_DEPTH - 1)) ? '0 : head_ff + 1'b1;
         if (count_ff != CW'(HIST_DEPTH)) count_in = count_ff + 1'b1;
      end else if (cmd.clear) begin
         head_in  = '0;
         count_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   // frame working registers
   logic [31:0] ts_ff, t_ff, pt_ff, ct_ff;
   logic [6:0]  i_ff;
   logic signed [15:0] py_ff, pz_ff, cy_ff, cz_ff, ry_ff, rz_ff;
   logic signed [23:0] accx_ff, accy_ff;
   logic        fail_ff;
   logic signed [NUM_W-1:0] num_ff, num_in;
   logic [31:0] den_ff, den_in;

   // operand selection and multiply ahead of the divider
   logic [31:0]        dt, span;
   logic signed [16:0] diff;
   logic signed [15:0] srate;
   logic [16:0]        prod_ip;
   always_comb begin
      dt      = t_ff - pt_ff;
      span    = ct_ff - pt_ff;
      diff    = (cmd.op == OP_INTY) ? 17'(cy_ff) - 17'(py_ff) : 17'(cz_ff) - 17'(pz_ff);
      srate   = (cmd.op == OP_SHX) ? rz_ff : (vert_ff ? ry_ff : 16'sd0);
      prod_ip = 17'(i_ff) * 17'(period_ff);
      num_in  = '0;
      den_in  = '0;
      unique case (cmd.op)
         OP_OFF: begin
            num_in = NUM_W'({prod_ip, 1'b0});
            den_in = 32'({n_eff, 1'b0});
         end
         OP_INTY, OP_INTZ: begin
            num_in = $signed({1'b0, dt}) * diff;
            den_in = span;
         end
         OP_SHX, OP_SHY: begin
            num_in = srate * $signed({1'b0, gain_ff});
            den_in = 32'({n_eff, 12'b0});
         end
         default: ;
      endcase
   end

   // rounding: magnitude plus half divisor, sign restored afterwards
   logic                 neg;
   logic [NUM_W-1:0]     mag;
   logic [DIV_NUM_W-1:0] dividend, quo;
   logic                 div_done;
   logic signed [24:0]   q25;
   logic signed [17:0]   q18;

   assign neg      = num_ff[NUM_W-1];
   assign mag      = neg ? NUM_W'(-num_ff) : NUM_W'(num_ff);
   assign dividend = DIV_NUM_W'(mag) + DIV_NUM_W'(den_ff >> 1);
   assign q25      = neg ? -$signed(quo[24:0]) : $signed(quo[24:0]);
   assign q18      = neg ? -$signed(quo[17:0]) : $signed(quo[17:0]);

   grss_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (dividend),
      .divisor  (den_ff),
      .quotient (quo),
      .done     (div_done)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff    <= '0;
         fail_ff <= 1'b0;
         i_ff    <= 7'd1;
      end else begin
         k_ff <= k_in;
         if (cmd.frame_start || cmd.next_div) fail_ff <= 1'b0;
         else if (cmd.set_fail) fail_ff <= 1'b1;
         if (cmd.frame_start) i_ff <= 7'd1;
         else if (cmd.next_div) i_ff <= i_ff + 1'b1;
      end
      if (cmd.frame_start) begin
         ts_ff   <= req_timestamp;
         accx_ff <= '0;
         accy_ff <= '0;
      end
      if (cmd.num_load) begin
         num_ff <= num_in;
         den_ff <= den_in;
      end
      if (cmd.scan_next) begin
         pt_ff <= rd_t;
         py_ff <= rd_y;
         pz_ff <= rd_z;
      end
      if (cmd.latch_a) begin
         ct_ff <= rd_t;
         cy_ff <= rd_y;
         cz_ff <= rd_z;
      end
      if (cmd.set_fallback) begin
         ry_ff <= rd_y;
         rz_ff <= rd_z;
      end
      if (cmd.div_store) begin
         unique case (cmd.op)
            OP_OFF:  t_ff <= ts_ff - quo[31:0];
            OP_INTY: ry_ff <= 16'(18'(py_ff) + q18);
            OP_INTZ: rz_ff <= 16'(18'(pz_ff) + q18);
            OP_SHX:  accx_ff <= sat24(25'(accx_ff) + q25);
            OP_SHY:  accy_ff <= sat24(25'(accy_ff) + q25);
            default: ;
         endcase
      end
   end

   always_comb begin
      k_in = k_ff;
      if (cmd.div_store && cmd.op == OP_OFF) k_in = '0;
      else if (cmd.scan_next) k_in = k_ff + 1'b1;
   end

   assign sts.div_done   = div_done;
   assign sts.hist_empty = (count_ff == '0);
   assign sts.ge         = (rd_t >= t_ff);
   assign sts.k_first    = (k_ff == '0);
   assign sts.k_last     = (k_ff == count_ff - 1'b1);
   assign sts.fb_ok      = ((t_ff - rd_t) <= {16'b0, maxdly_ff});
   assign sts.last_div   = (i_ff == n_eff);

   assign rsp_shift_x     = accx_ff;
   assign rsp_shift_y     = accy_ff;
   assign rsp_band_failed = fail_ff;
   assign rsp_last_band   = (i_ff == n_eff);
endmodule

FILE: rtl/core/grss_ctrl.sv
// Controller: sequences loads, history scan and the divider passes per band.
// Depends on grss_pkg.
module grss_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic [1:0]        req_action,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   input  grss_pkg::sts_type sts,
   output grss_pkg::cmd_type cmd
);
   import grss_pkg::*;

   typedef enum logic [6:0] {
      S_IDLE     = 7'b0000001,
      S_LD       = 7'b0000010,
      S_GO       = 7'b0000100,
      S_WAIT     = 7'b0001000,
      S_SCAN_RD  = 7'b0010000,
      S_SCAN_CHK = 7'b0100000,
      S_EMIT     = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   op_type    op_ff, op_in;

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      cmd      = '0;
      cmd.op   = op_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               unique case (action_type'(req_action))
                  ACT_LOAD:  cmd.load = 1'b1;
                  ACT_CLEAR: cmd.clear = 1'b1;
                  ACT_FRAME: begin
                     cmd.frame_start = 1'b1;
                     op_in    = OP_OFF;
                     state_in = S_LD;
                  end
                  default: ;
               endcase
            end
         end
         S_LD: begin
            cmd.num_load = 1'b1;
            state_in = S_GO;
         end
         S_GO: begin
            cmd.div_start = 1'b1;
            state_in = S_WAIT;
         end
         S_WAIT: begin
            if (sts.div_done) begin
               cmd.div_store = 1'b1;
               unique case (op_ff)
                  OP_OFF: begin
                     if (sts.hist_empty) begin
                        cmd.set_fail = 1'b1;
                        state_in = S_EMIT;
                     end else begin
                        state_in = S_SCAN_RD;
                     end
                  end
                  OP_INTY: begin
                     op_in = OP_INTZ;
                     state_in = S_LD;
                  end
                  OP_INTZ: begin
                     op_in = OP_SHX;
                     state_in = S_LD;
                  end
                  OP_SHX: begin
                     op_in = OP_SHY;
                     state_in = S_LD;
                  end
                  default: state_in = S_EMIT;
               endcase
            end
         end
         S_SCAN_RD: state_in = S_SCAN_CHK;
         S_SCAN_CHK: begin
            if (sts.ge) begin
               if (sts.k_first) begin
                  cmd.set_fail = 1'b1;
                  state_in = S_EMIT;
               end else begin
                  cmd.latch_a = 1'b1;
                  op_in = OP_INTY;
                  state_in = S_LD;
               end
            end else if (sts.k_last) begin
               // nothing at or after the band time: fall back to newest sample
               if (sts.fb_ok) begin
                  cmd.set_fallback = 1'b1;
                  op_in = OP_SHX;
                  state_in = S_LD;
               end else begin
                  cmd.set_fail = 1'b1;
                  state_in = S_EMIT;
               end
            end else begin
               cmd.scan_next = 1'b1;
               state_in = S_SCAN_RD;
            end
         end
         S_EMIT: begin
            if (!rsp_stall) begin
               if (sts.last_div) begin
                  state_in = S_IDLE;
               end else begin
                  cmd.next_div = 1'b1;
                  op_in = OP_OFF;
                  state_in = S_LD;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         op_ff    <= OP_OFF;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_EMIT);
endmodule

FILE: rtl/core/gyro_rolling_shutter_shift.sv
// Channel  Direction  Handshake          Payload
// req      in         req_valid/stall    action, timestamp, gyro_y, gyro_z
// rsp      out        rsp_valid/stall    shift_x, shift_y, band_failed, last_band
// csr      in         csr_valid/ready    csr_index, csr_data
//
// Load and clear items are handled in the idle state. A frame item emits one result
// per band; each band makes an offset pass of the bit-serial divider, scans the
// history and ends with an emit; two interpolation and two shift passes come between
// when data is found, only the two shift passes on fallback to the newest sample.
// Synchronous active-high reset; the history contents need no clearing. A stalled
// result holds the block until taken. Depends on grss_pkg, grss_ctrl, grss_dp.
module gyro_rolling_shutter_shift #(
   parameter int HIST_DEPTH = 32,
   parameter int MAX_DIV    = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_action,
   input  logic [31:0]        req_timestamp,
   input  logic signed [15:0] req_gyro_y,
   input  logic signed [15:0] req_gyro_z,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [23:0] rsp_shift_x,
   output logic signed [23:0] rsp_shift_y,
   output logic               rsp_band_failed,
   output logic               rsp_last_band,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [15:0]        csr_data
);
   import grss_pkg::*;

   cmd_type cmd;
   sts_type sts;

   assign csr_ready = 1'b1;

   grss_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_action),
      .req_stall  (req_stall),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .sts        (sts),
      .cmd        (cmd)
   );

   grss_dp #(.HIST_DEPTH(HIST_DEPTH), .MAX_DIV(MAX_DIV)) u_dp (
      .clock           (clock),
      .reset           (reset),
      .csr_valid       (csr_valid),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .req_timestamp   (req_timestamp),
      .req_gyro_y      (req_gyro_y),
      .req_gyro_z      (req_gyro_z),
      .cmd             (cmd),
      .sts             (sts),
      .rsp_shift_x     (rsp_shift_x),
      .rsp_shift_y     (rsp_shift_y),
      .rsp_band_failed (rsp_band_failed),
      .rsp_last_band   (rsp_last_band)
   );
endmodule

FILE: test/tb.sv
// Self-checking bench for gyro_rolling_shutter_shift: random gyro loads, clears and frames.
// Predicts per-band cumulative shifts in SV and compares them field by field.
// Depends on grss_pkg and the RTL top module.
module tb;
   import grss_pkg::*;

   typedef struct {
      logic [1:0]         action;
      logic [31:0]        timestamp;
      logic signed [15:0] gyro_y;
      logic signed [15:0] gyro_z;
   } req_item_type;

   typedef struct {
      logic signed [23:0] shift_x;
      logic signed [23:0] shift_y;
      logic               failed;
      logic               last;
   } band_type;

   logic clock = 0, reset = 1;
   logic req_valid = 0, rsp_stall = 0, csr_valid = 0;
   logic [1:0] req_action = 0;
   logic [31:0] req_timestamp = 0;
   logic signed [15:0] req_gyro_y = 0, req_gyro_z = 0;
   logic [2:0] csr_index = 0;
   logic [15:0] csr_data = 0;
   wire req_stall, rsp_valid, csr_ready, rsp_band_failed, rsp_last_band;
   wire signed [23:0] rsp_shift_x, rsp_shift_y;

   gyro_rolling_shutter_shift DUT (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   // predictor state
   logic [6:0]  p_ndiv = RST_NUM_DIV;
   logic [9:0]  p_period = RST_PERIOD;
   logic [15:0] p_gain = RST_GAIN;
   logic        p_vert = RST_VERT;
   logic [15:0] p_maxdly = RST_MAX_DLY;
   logic [31:0] h_time [32];
   longint      h_ry [32], h_rz [32];
   int          h_head = 0, h_count = 0;

   req_item_type pending_items[$];
   band_type     expected_bands[$];
   int errors = 0, bands_seen = 0, frames_sent = 0, fails_seen = 0;
   longint cycles = 0;
   bit long_hold = 0;

   function automatic longint round_div(longint num, longint den);
      longint m, q;
      m = num < 0 ? -num : num;
      q = (m + den / 2) / den;
      return num < 0 ? -q : q;
   endfunction

   function automatic longint clamp24(longint v);
      if (v > 8388607) return 8388607;
      if (v < -8388608) return -8388608;
      return v;
   endfunction

   function automatic bit rates_at(logic [31:0] t, output longint ry, output longint rz);
      int oldest, a, b;
      longint dt, span;
      logic [31:0] age;
      ry = 0; rz = 0;
      if (h_count == 0) return 0;
      oldest = (h_head + 32 - h_count) % 32;
      for (int k = 0; k < h_count; k++) begin
         a = (oldest + k) % 32;
         if (h_time[a] >= t) begin
            if (k == 0) return 0;
            b = (oldest + k - 1) % 32;
            dt = longint'(32'(t - h_time[b]));
            span = longint'(32'(h_time[a] - h_time[b]));
            ry = h_ry[b] + round_div(dt * (h_ry[a] - h_ry[b]), span);
            rz = h_rz[b] + round_div(dt * (h_rz[a] - h_rz[b]), span);
            return 1;
         end
      end
      a = (h_head + 31) % 32;
      age = t - h_time[a];
      if (age <= p_maxdly) begin
         ry = h_ry[a]; rz = h_rz[a];
         return 1;
      end
      return 0;
   endfunction

   task automatic predict_bands(req_item_type it);
      int n;
      longint off, acc_x, acc_y, ry, rz, den;
      logic [31:0] t;
      bit ok;
      band_type bnd;
      acc_x = 0; acc_y = 0;
      case (it.action)
         ACT_LOAD: begin
            h_time[h_head] = it.timestamp;
            h_ry[h_head] = it.gyro_y;
            h_rz[h_head] = it.gyro_z;
            h_head = (h_head + 1) % 32;
            if (h_count < 32) h_count++;
         end
         ACT_CLEAR: begin
            h_head = 0; h_count = 0;
         end
         ACT_FRAME: begin
            n = p_ndiv;
            if (n < 1) n = 1;
            if (n > 64) n = 64;
            for (int i = 1; i <= n; i++) begin
               off = (2 * i * longint'(p_period) + n) / (2 * n);
               t = it.timestamp - 32'(off);
               ok = rates_at(t, ry, rz);
               if (ok) begin
                  den = n * 4096;
                  if (!p_vert) ry = 0;
                  acc_x = clamp24(acc_x + round_div(rz * p_gain, den));
                  acc_y = clamp24(acc_y + round_div(ry * p_gain, den));
               end
               bnd.shift_x = 24'(acc_x);
               bnd.shift_y = 24'(acc_y);
               bnd.failed = !ok;
               bnd.last = (i == n);
               expected_bands.push_back(bnd);
            end
         end
         default: ;
      endcase
   endtask

   task automatic report(string what);
      $display("mismatch @%0t: %s", $time, what);
      errors++;
   endtask

   // driver
   int send_gap = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            req_valid <= 0;
            send_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 12);
         end else if (!req_valid) begin
            if (send_gap > 0) send_gap--;
            else if (pending_items.size() > 0) begin
               req_item_type it;
               it = pending_items.pop_front();
               predict_bands(it);
               if (it.action == ACT_FRAME) frames_sent++;
               req_action <= it.action;
               req_timestamp <= it.timestamp;
               req_gyro_y <= it.gyro_y;
               req_gyro_z <= it.gyro_z;
               req_valid <= 1;
            end
         end
      end
   end

   // monitor; the stall is redrawn per accepted result
   int recv_gap = 0;
   always @(posedge clock) begin
      cycles++;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            band_type e;
            bands_seen++;
            if (rsp_band_failed) fails_seen++;
            if (expected_bands.size() == 0) report("result with nothing expected");
            else begin
               e = expected_bands.pop_front();
               if (rsp_shift_x !== e.shift_x)
                  report($sformatf("shift_x %0d exp %0d", rsp_shift_x, e.shift_x));
               if (rsp_shift_y !== e.shift_y)
                  report($sformatf("shift_y %0d exp %0d", rsp_shift_y, e.shift_y));
               if (rsp_band_failed !== e.failed)
                  report($sformatf("band_failed %0b exp %0b", rsp_band_failed, e.failed));
               if (rsp_last_band !== e.last)
                  report($sformatf("last_band %0b exp %0b", rsp_last_band, e.last));
            end
            recv_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
         end
         if (long_hold) rsp_stall <= 1;
         else if (recv_gap > 0) begin
            recv_gap--;
            rsp_stall <= 1;
         end else rsp_stall <= 0;
      end
      if (cycles > 20000000) begin
         $display("timeout");
         $display("CHECK FAILED");
         $finish;
      end
   end

   task automatic csr_write(csr_idx_type idx, logic [15:0] val);
      @(posedge clock);
      csr_index <= idx;
      csr_data <= val;
      csr_valid <= 1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
      case (idx)
         CSR_NUM_DIV: p_ndiv = val[6:0];
         CSR_PERIOD:  p_period = val[9:0];
         CSR_GAIN:    p_gain = val;
         CSR_VERT:    p_vert = val[0];
         CSR_MAX_DLY: p_maxdly = val;
         default: ;
      endcase
   endtask

   task automatic push(logic [1:0] a, logic [31:0] ts, logic [15:0] y, logic [15:0] z);
      req_item_type it;
      it.action = a; it.timestamp = ts; it.gyro_y = y; it.gyro_z = z;
      pending_items.push_back(it);
   endtask

   task automatic drain();
      while (pending_items.size() > 0 || req_valid || expected_bands.size() > 0)
         @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   // a well-formed run: rising sample times, frames near the latest sample, some noise
   task automatic random_burst(int items);
      logic [31:0] ts;
      int step;
      ts = $urandom();
      step = $urandom_range(1, 20);
      for (int k = 0; k < items; k++) begin
         int r;
         r = $urandom_range(0, 19);
         if (r < 13) begin
            ts += $urandom_range(1, step);
            push(ACT_LOAD, ts, 16'($urandom()), 16'($urandom()));
         end else if (r < 17)
            push(ACT_FRAME, ts + $urandom_range(0, 60) - 20, 16'($urandom()),
                 16'($urandom()));
         else if (r < 18) push(ACT_CLEAR, $urandom(), 16'($urandom()), 16'($urandom()));
         else if (r < 19) push(ACT_NONE, $urandom(), 16'($urandom()), 16'($urandom()));
         else push(ACT_LOAD, $urandom(), 16'($urandom()), 16'($urandom()));
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 0;

      // reset settings, empty history, then extremes of the input fields
      push(ACT_FRAME, 32'd1000, 0, 0);
      push(ACT_LOAD, 32'd0, 16'h8000, 16'h7FFF);
      push(ACT_FRAME, 32'd5, 0, 0);
      push(ACT_LOAD, 32'd10, 16'h7FFF, 16'h8000);
      push(ACT_LOAD, 32'd40, 16'h0000, 16'hFFFF);
      push(ACT_FRAME, 32'd40, 0, 0);
      push(ACT_FRAME, 32'd200, 0, 0);
      push(ACT_NONE, 32'hFFFFFFFF, 16'hFFFF, 16'hFFFF);
      push(ACT_CLEAR, 0, 0, 0);
      push(ACT_FRAME, 32'd40, 0, 0);
      drain();

      csr_write(CSR_GAIN, 16'hFFFF);
      csr_write(CSR_NUM_DIV, 16'd1);
      csr_write(CSR_MAX_DLY, 16'hFFFF);
      // wrap of the time subtraction and a full, overwritten history
      for (int k = 0; k < 40; k++)
         push(ACT_LOAD, 32'hFFFFFFF0 + k * 3, 16'($urandom()), 16'($urandom()));
      push(ACT_FRAME, 32'd2, 0, 0);
      push(ACT_FRAME, 32'hFFFFFFFF, 0, 0);
      drain();

      csr_write(CSR_NUM_DIV, 16'd64);
      csr_write(CSR_PERIOD, 16'd1000);
      csr_write(CSR_VERT, 16'd0);
      csr_write(CSR_MAX_DLY, 16'd0);
      push(ACT_CLEAR, 0, 0, 0);
      for (int k = 0; k < 8; k++) push(ACT_LOAD, k * 150, 16'h7FFF, 16'h7FFF);
      push(ACT_FRAME, 32'd1100, 0, 0);
      drain();

      csr_write(CSR_NUM_DIV, 16'd0);
      csr_write(CSR_PERIOD, 16'd0);
      csr_write(CSR_VERT, 16'd1);
      push(ACT_FRAME, 32'd1050, 0, 0);
      drain();
      csr_write(CSR_NUM_DIV, 16'd127);
      csr_write(CSR_PERIOD, 16'd7);
      push(ACT_FRAME, 32'd1051, 0, 0);
      drain();

      // random phases over several settings, with one long receiver hold
      for (int ph = 0; ph < 5; ph++) begin
         csr_write(CSR_NUM_DIV, 16'($urandom_range(1, 12)));
         csr_write(CSR_PERIOD, 16'($urandom_range(0, 1000)));
         csr_write(CSR_GAIN, 16'($urandom()));
         csr_write(CSR_VERT, 16'($urandom_range(0, 1)));
         csr_write(CSR_MAX_DLY, 16'($urandom_range(0, 300)));
         if (ph == 2) begin
            long_hold = 1;
            random_burst(14);
            repeat (400) @(posedge clock);
            long_hold = 0;
         end else random_burst(14);
         drain();
      end

      $display("frames sent %0d, bands checked %0d (%0d without gyro data)",
               frames_sent, bands_seen, fails_seen);
      if (errors == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end
endmodule
